// ----- rtl/core/cmd_pkg.sv -----
// Shared constants, configuration register codes and the sine table generator
// for the chorus modulated delay. No dependencies; used by chorus_modulated_delay.
`default_nettype none

package cmd_pkg;

  // Default sizes for the top level's parameters.
  localparam int unsigned LineDepthDefault     = 1024;
  localparam int unsigned SineTableBitsDefault = 8;

  // Field and register widths.
  localparam int unsigned SampleW    = 16;
  localparam int unsigned BaseDelayW = 18;
  localparam int unsigned ModDepthW  = 18;
  localparam int unsigned PhaseW     = 32;
  localparam int unsigned LineLenW   = 11;
  localparam int unsigned WetGainW   = 16;
  localparam int unsigned SineW      = 15;
  localparam int unsigned CfgW       = 32;
  localparam int unsigned CfgIdxW    = 3;

  // Shared serial multiplier: multiplicand and multiplier widths.
  localparam int unsigned MulAW = 24;
  localparam int unsigned MulBW = 16;

  // Signed width of the delay in samples with 8 fraction bits.
  localparam int unsigned DelayW = 21;

  // Register reset values.
  localparam logic [BaseDelayW-1:0] BaseDelayRst  = 18'd184320;
  localparam logic [ModDepthW-1:0]  ModDepthRst   = 18'd49152;
  localparam logic [PhaseW-1:0]     PhaseStepRst  = 32'd71583;
  localparam logic [LineLenW-1:0]   LineLengthRst = 11'd962;
  localparam logic [WetGainW-1:0]   WetGainRst    = 16'd16384;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBaseDelay  = 3'd0,
    CfgModDepth   = 3'd1,
    CfgPhaseStep  = 3'd2,
    CfgLineLength = 3'd3,
    CfgWetGain    = 3'd4
  } cfg_index_e;

  localparam longint HalfPiQ30 = 64'sd1686629713;

  // Truncated quotient of a non-negative dividend by a positive divisor,
  // by restoring long division one dividend bit at a time.
  function automatic longint div_nonneg(input longint num,
                                        input longint den);
    longint rem;
    longint quo;
    rem = 0;
    quo = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'sd1);
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry k of a 2^bits table, Q15, by a Taylor series on a
  // Q30 angle. Evaluated only at elaboration to fill the sine ROM.
  function automatic logic [SineW-1:0] sine_q15(input int unsigned k,
                                                input int unsigned bits);
    longint a;
    longint term;
    longint sum;
    longint q;
    a    = (HalfPiQ30 * longint'(k)) >>> bits;
    term = a;
    sum  = a;
    for (int n = 1; n <= 10; n++) begin
      term = (term * a) >>> 30;
      term = (term * a) >>> 30;
      term = div_nonneg(term, longint'((2 * n) * (2 * n + 1)));
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[SineW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cmd_serial_mul.sv -----
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Standalone; instantiated by chorus_modulated_delay.
`default_nettype none

module cmd_serial_mul #(
  parameter int unsigned AW = 24,
  parameter int unsigned BW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             busy_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_q;
  logic [AW+BW-1:0] acc_d;
  logic [AW-1:0]    mcand_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic [AW:0]      sum;
  logic [AW+BW:0]   shifted;

  // The upper half collects partial sums while the multiplier drains from
  // the lower half, least significant bit first.
  always_comb begin
    sum     = {1'b0, acc_q[AW+BW-1:BW]} + (acc_q[0] ? {1'b0, mcand_q} : '0);
    shifted = {sum, acc_q[BW-1:0]} >> 1;
    acc_d   = shifted[AW+BW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(BW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= {{AW{1'b0}}, b_i};
      mcand_q <= a_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ----- rtl/core/cmd_serial_mod.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Standalone; instantiated by chorus_modulated_delay.
`default_nettype none

module cmd_serial_mod #(
  parameter int unsigned XW = 13,
  parameter int unsigned MW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [XW-1:0] x_i,
  input  logic [MW-1:0] m_i,
  output logic          busy_o,
  output logic [MW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(XW + 1);

  logic [XW-1:0] x_q;
  logic [MW-1:0] m_q;
  logic [MW-1:0] r_q;
  logic [MW-1:0] r_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [MW:0]   trial;
  logic [MW:0]   diff;

  // The partial remainder stays below the modulus, so one trial subtraction
  // per bit is enough.
  always_comb begin
    trial = {r_q, x_q[XW-1]};
    diff  = trial - {1'b0, m_q};
    r_d   = (trial >= {1'b0, m_q}) ? diff[MW-1:0] : trial[MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(XW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      m_q <= m_i;
      r_q <= '0;
    end else if (busy_q) begin
      x_q <= x_q << 1;
      r_q <= r_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

// ----- rtl/core/chorus_modulated_delay.sv -----
// Chorus: one item is worked on at a time; a new item is taken only once the
// last result is in the output register. XW, the dividend width of the
// remainder unit, is 13 for LINE_DEPTH 1024. Each item passes through three
// 16-step serial multiplications and two serial remainders.
// After reset the delay line is swept to zero, one entry a cycle, over all
// LINE_DEPTH entries; no item is taken meanwhile, configuration writes are.
// Depends on cmd_pkg, cmd_serial_mul and cmd_serial_mod.
`default_nettype none

module chorus_modulated_delay #(
  parameter int unsigned LINE_DEPTH      = cmd_pkg::LineDepthDefault,
  parameter int unsigned SINE_TABLE_BITS = cmd_pkg::SineTableBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [cmd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cmd_pkg::CfgW-1:0]     cfg_data_i,
  // Input item channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [cmd_pkg::SampleW-1:0] sample_in_i,
  // Result item channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [cmd_pkg::SampleW-1:0] sample_out_o
);

  import cmd_pkg::*;

  // Address and length widths of the delay line.
  localparam int unsigned AddrW   = $clog2(LINE_DEPTH);
  localparam int unsigned LenW    = $clog2(LINE_DEPTH + 1);
  localparam int unsigned CmpW    = (LenW > LineLenW) ? LenW : LineLenW;
  // Sine ROM holds a quarter wave plus its end point.
  localparam int unsigned QtrSize = 1 << SINE_TABLE_BITS;
  localparam int unsigned RomAW   = SINE_TABLE_BITS + 1;
  // The read position in samples times 256 spans the line plus the largest
  // delay either way; its whole-sample part is what the remainder unit sees.
  localparam int unsigned PosW    = ((AddrW + 8 > 19) ? AddrW + 8 : 19) + 2;
  localparam int unsigned PW      = PosW - 8;
  localparam int unsigned ProdW   = MulAW + MulBW;

  // Sequencer states.
  localparam logic [3:0] StClear   = 4'd0;
  localparam logic [3:0] StIdle    = 4'd1;
  localparam logic [3:0] StStart   = 4'd2;
  localparam logic [3:0] StDlyWait = 4'd3;
  localparam logic [3:0] StPos     = 4'd4;
  localparam logic [3:0] StIdxWait = 4'd5;
  localparam logic [3:0] StRd0     = 4'd6;
  localparam logic [3:0] StRd1     = 4'd7;
  localparam logic [3:0] StInt     = 4'd8;
  localparam logic [3:0] StIntWait = 4'd9;
  localparam logic [3:0] StWet     = 4'd10;
  localparam logic [3:0] StWetWait = 4'd11;
  localparam logic [3:0] StOut     = 4'd12;

  // Configuration registers.
  logic [BaseDelayW-1:0] base_delay_q;
  logic [ModDepthW-1:0]  mod_depth_q;
  logic [PhaseW-1:0]     phase_step_q;
  logic [LineLenW-1:0]   line_length_q;
  logic [WetGainW-1:0]   wet_gain_q;

  // Control and persistent state.
  logic [3:0]            state_q;
  logic [3:0]            state_d;
  logic [AddrW-1:0]      clr_q;
  logic [AddrW-1:0]      wp_q;
  logic [PhaseW-1:0]     lfo_phase_q;
  logic                  out_valid_q;

  // Per-item working registers.
  logic [LenW-1:0]       len_q;
  logic signed [SampleW-1:0] dry_q;
  logic [SineW-1:0]      sine_q;
  logic                  sneg_q;
  logic [AddrW-1:0]      wp_eff_q;
  logic signed [DelayW-1:0] d_q;
  logic [7:0]            frac_q;
  logic                  pneg_q;
  logic [AddrW-1:0]      i0_q;
  logic signed [SampleW-1:0] a_q;
  logic                  dneg_q;
  logic signed [24:0]    val_q;
  logic                  vneg_q;
  logic signed [18:0]    t_q;
  logic signed [SampleW-1:0] out_data_q;

  // Delay line memory and sine ROM.
  logic [SampleW-1:0]    line_mem [LINE_DEPTH];
  logic [SampleW-1:0]    rd_data_q;
  logic [SineW-1:0]      sine_rom [QtrSize + 1];

  logic                  in_accept;
  logic                  out_free;
  logic                  units_idle;

  logic [CmpW-1:0]       ll_ext;
  logic [LenW-1:0]       len_calc;
  logic [1:0]            quad;
  logic [SINE_TABLE_BITS-1:0] sidx;
  logic [RomAW-1:0]      rom_addr;

  logic                  mul_start;
  logic [MulAW-1:0]      mul_a;
  logic [MulBW-1:0]      mul_b;
  logic                  mul_busy;
  logic [ProdW-1:0]      mul_prod;

  logic                  mod_start;
  logic [PW-1:0]         mod_x;
  logic                  mod_busy;
  logic [LenW-1:0]       mod_rem;

  logic [AddrW-1:0]      wp_eff;
  logic [AddrW-1:0]      wp_next;
  logic signed [33:0]    dterm_full;
  logic signed [33:0]    dterm_sh;
  logic signed [DelayW-1:0] d_next;
  logic signed [PosW-1:0] wp_scaled;
  logic signed [PosW-1:0] pos_raw;
  logic signed [PW-1:0]  p_whole;
  logic [PW-1:0]         pmag;
  logic [LenW-1:0]       i0_wide;
  logic [AddrW-1:0]      i1;
  logic signed [16:0]    diff;
  logic [15:0]           dmag;
  logic signed [24:0]    interp;
  logic signed [24:0]    val_next;
  logic [23:0]           vmag;
  logic signed [ProdW:0] wet_full;
  logic signed [ProdW:0] wet_rnd;
  logic signed [ProdW:0] wet_sh;
  logic signed [19:0]    mix;
  logic signed [SampleW-1:0] mix_sat;

  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [SampleW-1:0]    mem_wdata;
  logic [AddrW-1:0]      mem_raddr;

  // ---------------------------------------------------------------------
  // Sine ROM, filled at elaboration from the Taylor series in the package.
  // ---------------------------------------------------------------------
  for (genvar gk = 0; gk <= QtrSize; gk++) begin : g_sine
    localparam logic [SineW-1:0] Entry = sine_q15(gk, SINE_TABLE_BITS);
    assign sine_rom[gk] = Entry;
  end

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are taken in any state; the user only
  // writes while no item is in flight.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_delay_q  <= BaseDelayRst;
      mod_depth_q   <= ModDepthRst;
      phase_step_q  <= PhaseStepRst;
      line_length_q <= LineLengthRst;
      wet_gain_q    <= WetGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBaseDelay:  base_delay_q  <= cfg_data_i[BaseDelayW-1:0];
        CfgModDepth:   mod_depth_q   <= cfg_data_i[ModDepthW-1:0];
        CfgPhaseStep:  phase_step_q  <= cfg_data_i[PhaseW-1:0];
        CfgLineLength: line_length_q <= cfg_data_i[LineLenW-1:0];
        CfgWetGain:    wet_gain_q    <= cfg_data_i[WetGainW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. One item is worked on at a time; the output register lets
  // the next item in while a result still waits to be taken.
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && (state_q == StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign units_idle = !mul_busy && !mod_busy;

  // Effective line length: clamped into [2, LINE_DEPTH].
  always_comb begin
    ll_ext = CmpW'(line_length_q);
    if (ll_ext < CmpW'(2)) begin
      len_calc = LenW'(2);
    end else if (ll_ext > CmpW'(LINE_DEPTH)) begin
      len_calc = LenW'(LINE_DEPTH);
    end else begin
      len_calc = LenW'(ll_ext);
    end
  end

  // The LFO phase picks a quadrant and a table entry; odd quadrants read the
  // table backwards, the lower half-turn negates.
  always_comb begin
    quad     = lfo_phase_q[PhaseW-1 -: 2];
    sidx     = lfo_phase_q[PhaseW-3 -: SINE_TABLE_BITS];
    rom_addr = quad[0] ? (RomAW'(QtrSize) - {1'b0, sidx}) : {1'b0, sidx};
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:   if (clr_q == AddrW'(LINE_DEPTH - 1)) state_d = StIdle;
      StIdle:    if (in_valid_i) state_d = StStart;
      StStart:   state_d = StDlyWait;
      StDlyWait: if (units_idle) state_d = StPos;
      StPos:     state_d = StIdxWait;
      StIdxWait: if (!mod_busy) state_d = StRd0;
      StRd0:     state_d = StRd1;
      StRd1:     state_d = StInt;
      StInt:     state_d = StIntWait;
      StIntWait: if (!mul_busy) state_d = StWet;
      StWet:     state_d = StWetWait;
      StWetWait: if (!mul_busy) state_d = StOut;
      StOut:     if (out_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      wp_q        <= '0;
      lfo_phase_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) begin
        clr_q <= clr_q + AddrW'(1);
      end
      // The pointer and the phase move on once the new sample is stored.
      if (state_q == StDlyWait && units_idle) begin
        wp_q        <= wp_next;
        lfo_phase_q <= lfo_phase_q + phase_step_q;
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared serial units. The multiplier serves, in turn, depth times sine,
  // neighbour difference times fraction, and wet gain times the
  // interpolated value. The remainder unit reduces first the write pointer
  // and then the read position by the line length.
  // ---------------------------------------------------------------------
  assign mul_start = (state_q == StStart) || (state_q == StInt) || (state_q == StWet);
  assign mod_start = (state_q == StStart) || (state_q == StPos);

  always_comb begin
    unique case (state_q)
      StStart: begin
        mul_a = MulAW'(mod_depth_q);
        mul_b = MulBW'(sine_q);
      end
      StInt: begin
        mul_a = MulAW'(dmag);
        mul_b = MulBW'(frac_q);
      end
      default: begin
        mul_a = vmag;
        mul_b = wet_gain_q;
      end
    endcase
    mod_x = (state_q == StPos) ? pmag : PW'(wp_q);
  end

  cmd_serial_mul #(
    .AW (MulAW),
    .BW (MulBW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  cmd_serial_mod #(
    .XW (PW),
    .MW (LenW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .x_i     (mod_x),
    .m_i     (len_q),
    .busy_o  (mod_busy),
    .rem_o   (mod_rem)
  );

  // ---------------------------------------------------------------------
  // Datapath arithmetic between the serial steps.
  // ---------------------------------------------------------------------
  always_comb begin
    // Write pointer reduced by the current length, and its successor.
    wp_eff  = mod_rem[AddrW-1:0];
    wp_next = ((LenW'(wp_eff) + LenW'(1)) == len_q) ? '0 : wp_eff + AddrW'(1);

    // Delay = base + floor(depth * sine / 2^15), with the sine's sign
    // applied to the unsigned product.
    dterm_full = sneg_q ? -$signed({1'b0, mul_prod[32:0]})
                        : $signed({1'b0, mul_prod[32:0]});
    dterm_sh   = dterm_full >>> 15;
    d_next     = $signed(DelayW'(base_delay_q)) + dterm_sh[DelayW-1:0];

    // Read position behind the write pointer. Its low byte is the fraction;
    // the whole part is reduced by the length as a magnitude and mirrored
    // afterwards when negative, which equals a floored remainder.
    wp_scaled = $signed(PosW'({wp_eff_q, 8'h00}));
    pos_raw   = wp_scaled - PosW'(d_q);
    p_whole   = pos_raw[PosW-1:8];
    pmag      = p_whole[PW-1] ? PW'(-p_whole) : PW'(p_whole);

    i0_wide = (pneg_q && (mod_rem != '0)) ? (len_q - mod_rem) : mod_rem;
    i1      = ((LenW'(i0_q) + LenW'(1)) == len_q) ? '0 : i0_q + AddrW'(1);

    // Linear interpolation written as a*256 + (b - a)*f.
    diff     = $signed({rd_data_q[SampleW-1], rd_data_q}) - $signed({a_q[SampleW-1], a_q});
    dmag     = diff[16] ? 16'(-diff) : diff[15:0];
    interp   = dneg_q ? -$signed({1'b0, mul_prod[23:0]})
                      : $signed({1'b0, mul_prod[23:0]});
    val_next = $signed({a_q[SampleW-1], a_q, 8'h00}) + interp;
    vmag     = val_q[24] ? 24'(-val_q) : val_q[23:0];

    // Wet part: gain * value / 2^22, rounded half up.
    wet_full = vneg_q ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
    wet_rnd  = wet_full + $signed((ProdW + 1)'(1 << 21));
    wet_sh   = wet_rnd >>> 22;

    // Dry plus wet, saturated to the sample range.
    mix = $signed({{4{dry_q[SampleW-1]}}, dry_q}) + $signed({t_q[18], t_q});
    if (mix > 20'sd32767) begin
      mix_sat = 16'sh7fff;
    end else if (mix < -20'sd32768) begin
      mix_sat = 16'sh8000;
    end else begin
      mix_sat = mix[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dry_q  <= sample_in_i;
      len_q  <= len_calc;
      sine_q <= sine_rom[rom_addr];
      sneg_q <= quad[1];
    end
    if (state_q == StDlyWait && units_idle) begin
      wp_eff_q <= wp_eff;
      d_q      <= d_next;
    end
    if (state_q == StPos) begin
      frac_q <= pos_raw[7:0];
      pneg_q <= p_whole[PW-1];
    end
    if (state_q == StIdxWait && !mod_busy) begin
      i0_q <= i0_wide[AddrW-1:0];
    end
    if (state_q == StRd1) begin
      a_q <= rd_data_q;
    end
    if (state_q == StInt) begin
      dneg_q <= diff[16];
    end
    if (state_q == StIntWait && !mul_busy) begin
      val_q <= val_next;
    end
    if (state_q == StWet) begin
      vneg_q <= val_q[24];
    end
    if (state_q == StWetWait && !mul_busy) begin
      t_q <= wet_sh[18:0];
    end
    if (state_q == StOut && out_free) begin
      out_data_q <= mix_sat;
    end
  end

  // ---------------------------------------------------------------------
  // Delay line: one write and one registered read a cycle. The sweep after
  // reset and the store of each new sample share the write port; the store
  // always comes before the two neighbour reads.
  // ---------------------------------------------------------------------
  always_comb begin
    mem_we    = (state_q == StClear) || (state_q == StDlyWait && units_idle);
    mem_waddr = (state_q == StClear) ? clr_q : wp_eff;
    mem_wdata = (state_q == StClear) ? '0 : dry_q;
    mem_raddr = (state_q == StRd1) ? i1 : i0_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= line_mem[mem_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_idx_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRd0) |-> (LenW'(i0_q) < len_q))
    else $error("interpolation index beyond the line length");

  a_wp_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPos) |-> (LenW'(wp_eff_q) < len_q))
    else $error("reduced write pointer beyond the line length");

  a_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (!mul_busy && !mod_busy))
    else $error("serial unit still busy while waiting for an item");

  a_no_result_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !out_valid_q)
    else $error("result produced during the delay line sweep");

endmodule

`default_nettype wire
